### rtl/cfps_pkg.sv
// Shared types and constants for the complex FIR pulse shaper.
package cfps_pkg;

	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 6;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int FRAC_W   = 15;
	localparam int SAT_MAX  = 32767;
	localparam int SAT_MIN  = -32768;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Per-request control broadcast from the top level to every tap cell.
	typedef struct packed {
		logic                       shift;
		logic                       load;
		logic [INDEX_W-1:0]         index;
		logic signed [SAMPLE_W-1:0] value;
	} cfps_ctrl_t;

endpackage

### rtl/cfps_tap_cell.sv
// One tap of the filter: held I/Q sample, tap weight, multipliers and partial sums.
module cfps_tap_cell #(
	parameter int ACC_W     = 38,
	parameter int TAP_INDEX = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  cfps_pkg::cfps_ctrl_t                     ctrl,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0]     i_in,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0]     q_in,
	output logic signed [cfps_pkg::SAMPLE_W-1:0]     i_out,
	output logic signed [cfps_pkg::SAMPLE_W-1:0]     q_out,
	input  logic signed [ACC_W-1:0]                  psum_i_in,
	input  logic signed [ACC_W-1:0]                  psum_q_in,
	output logic signed [ACC_W-1:0]                  psum_i_out,
	output logic signed [ACC_W-1:0]                  psum_q_out
);
	import cfps_pkg::*;

	localparam int IDX_W = INDEX_W + 1;

	logic signed [SAMPLE_W-1:0] i_q;
	logic signed [SAMPLE_W-1:0] q_q;
	logic signed [SAMPLE_W-1:0] weight_q;
	logic signed [PROD_W-1:0]   prod_i_s1;
	logic signed [PROD_W-1:0]   prod_q_s1;
	logic signed [ACC_W-1:0]    psum_i_q;
	logic signed [ACC_W-1:0]    psum_q_q;
	logic                       load_hit;

	assign load_hit = ctrl.load && ({1'b0, ctrl.index} == IDX_W'(TAP_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			q_q      <= '0;
			weight_q <= '0;
		end else begin
			if (ctrl.shift) begin
				i_q <= i_in;
				q_q <= q_in;
			end
			if (load_hit) begin
				weight_q <= ctrl.value;
			end
		end
	end

	// Product stage, then the partial sum handed on to the next cell.
	always_ff @(posedge clk) begin
		prod_i_s1 <= i_q * weight_q;
		prod_q_s1 <= q_q * weight_q;
		psum_i_q  <= psum_i_in + ACC_W'(prod_i_s1);
		psum_q_q  <= psum_q_in + ACC_W'(prod_q_s1);
	end

	assign i_out      = i_q;
	assign q_out      = q_q;
	assign psum_i_out = psum_i_q;
	assign psum_q_out = psum_q_q;

endmodule

### rtl/cfps_round_sat.sv
// Rounds a Q8.30 sum to Q1.15 (ties upward) and saturates to 16 bits.
module cfps_round_sat #(
	parameter int ACC_W = 38
) (
	input  logic signed [ACC_W-1:0]                  acc,
	output logic signed [cfps_pkg::SAMPLE_W-1:0]     result,
	output logic                                     clip
);
	import cfps_pkg::*;

	localparam int Q_W = ACC_W - FRAC_W;
	localparam logic signed [Q_W-1:0] HI_Q = Q_W'(SAT_MAX);
	localparam logic signed [Q_W-1:0] LO_Q = Q_W'(SAT_MIN);

	logic signed [ACC_W-1:0] biased;
	logic signed [Q_W-1:0]   shifted;

	assign biased  = acc + ACC_W'(1 << (FRAC_W - 1));
	assign shifted = biased[ACC_W-1:FRAC_W];

	always_comb begin
		if (shifted > HI_Q) begin
			result = SAMPLE_W'(SAT_MAX);
			clip   = 1'b1;
		end else if (shifted < LO_Q) begin
			result = SAMPLE_W'(SAT_MIN);
			clip   = 1'b1;
		end else begin
			result = shifted[SAMPLE_W-1:0];
			clip   = 1'b0;
		end
	end

endmodule

### rtl/complex_fir_pulse_shaper.sv
// Complex I/Q FIR pulse shaper: a row of tap cells with a partial-sum chain.
//
// Input channel (in_valid / in_stall) carries one request per accept. A
// request with op = load writes coeff_value into tap coeff_index in the same
// edge; indexes at or beyond TAP_COUNT are dropped. A load gives no result and
// leaves the block idle. A request with op = sample shifts the I/Q pair into the
// tap row (newest at the last tap, oldest meeting tap 0) and starts a pass.
// The partial sum walks one tap cell per cycle down the partial-sum chain;
// the sum out of the last cell is rounded, saturated and loaded into the
// output register, which ends the pass and lets the next request in.
// in_stall is high for the whole pass.
// Output channel (out_valid / out_stall) carries i_result, q_result and
// clipped from an output register. While a finished result waits, requests of
// either kind are still taken; a following pass that ends with the register
// still full holds its sum until the receiver takes the waiting result.
// Reset clears every held sample and tap weight to zero and empties the
// output register; the block is idle and accepts requests once reset is released.
module complex_fir_pulse_shaper #(
	parameter int TAP_COUNT = 33
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [cfps_pkg::INDEX_W-1:0]         coeff_index,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] coeff_value,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] i_sample,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] q_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [cfps_pkg::SAMPLE_W-1:0] i_result,
	output logic signed [cfps_pkg::SAMPLE_W-1:0] q_result,
	output logic                                 clipped
);
	import cfps_pkg::*;

	localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
	localparam int DONE_CNT = TAP_COUNT + 1;
	localparam int CNT_W    = $clog2(TAP_COUNT + 2);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] i_result_q;
	logic signed [SAMPLE_W-1:0] q_result_q;
	logic                       clipped_q;

	logic                       in_accept;
	logic                       out_free;
	logic                       result_load;
	cfps_ctrl_t                 ctrl;

	logic signed [SAMPLE_W-1:0] i_link [TAP_COUNT+1];
	logic signed [SAMPLE_W-1:0] q_link [TAP_COUNT+1];
	logic signed [ACC_W-1:0]    psum_i_link [TAP_COUNT+1];
	logic signed [ACC_W-1:0]    psum_q_link [TAP_COUNT+1];

	logic signed [SAMPLE_W-1:0] i_rounded;
	logic signed [SAMPLE_W-1:0] q_rounded;
	logic                       i_clip;
	logic                       q_clip;

	assign in_stall    = (state_q == ST_BUSY);
	assign in_accept   = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign result_load = (state_q == ST_BUSY) && (cnt_q == CNT_W'(DONE_CNT)) && out_free;

	assign ctrl.shift = in_accept && (op == OP_SAMPLE);
	assign ctrl.load  = in_accept && (op == OP_LOAD);
	assign ctrl.index = coeff_index;
	assign ctrl.value = coeff_value;

	assign i_link[TAP_COUNT] = i_sample;
	assign q_link[TAP_COUNT] = q_sample;
	assign psum_i_link[0]    = '0;
	assign psum_q_link[0]    = '0;

	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
		cfps_tap_cell #(
			.ACC_W     (ACC_W),
			.TAP_INDEX (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.i_in       (i_link[k+1]),
			.q_in       (q_link[k+1]),
			.i_out      (i_link[k]),
			.q_out      (q_link[k]),
			.psum_i_in  (psum_i_link[k]),
			.psum_q_in  (psum_q_link[k]),
			.psum_i_out (psum_i_link[k+1]),
			.psum_q_out (psum_q_link[k+1])
		);
	end

	cfps_round_sat #(.ACC_W(ACC_W)) u_round_i (
		.acc    (psum_i_link[TAP_COUNT]),
		.result (i_rounded),
		.clip   (i_clip)
	);

	cfps_round_sat #(.ACC_W(ACC_W)) u_round_q (
		.acc    (psum_q_link[TAP_COUNT]),
		.result (q_rounded),
		.clip   (q_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			i_result_q  <= '0;
			q_result_q  <= '0;
			clipped_q   <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.shift) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					if (cnt_q != CNT_W'(DONE_CNT)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (out_free) begin
						// The last partial sum has settled; hand it to the output register.
						i_result_q  <= i_rounded;
						q_result_q  <= q_rounded;
						clipped_q   <= i_clip || q_clip;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign i_result  = i_result_q;
	assign q_result  = q_result_q;
	assign clipped   = clipped_q;

	a_result_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_BUSY) && $past(cnt_q == CNT_W'(DONE_CNT)))
		else $error("result appeared without a finished pass");

	a_sample_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |=> (state_q == ST_BUSY) && (cnt_q == '0))
		else $error("accepted sample did not start a pass");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DONE_CNT))
		else $error("pass counter ran past its end");

	a_clip_means_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clipped_q |->
			i_result_q == SAMPLE_W'(SAT_MAX) || i_result_q == SAMPLE_W'(SAT_MIN) ||
			q_result_q == SAMPLE_W'(SAT_MAX) || q_result_q == SAMPLE_W'(SAT_MIN))
		else $error("clip flag set on an unsaturated result");

endmodule

### tb/complex_fir_pulse_shaper_checker.sv
// Checker for the complex FIR pulse shaper: watches both channels, predicts results, compares.
`timescale 1ns / 1ps

module complex_fir_pulse_shaper_checker #(
	parameter int TAP_COUNT = 33
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 op,
	input  logic [cfps_pkg::INDEX_W-1:0]         coeff_index,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] coeff_value,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] i_sample,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] q_sample,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] i_result,
	input  logic signed [cfps_pkg::SAMPLE_W-1:0] q_result,
	input  logic                                 clipped,
	output int                                   error_count,
	output int                                   results_pending
);
	import cfps_pkg::*;

	localparam longint ROUND_HALF = longint'(1) << (FRAC_W - 1);

	typedef struct {
		logic signed [SAMPLE_W-1:0] i_val;
		logic signed [SAMPLE_W-1:0] q_val;
		logic                       clip;
	} shaped_sample_t;

	logic signed [SAMPLE_W-1:0] tap_weight [TAP_COUNT];
	// Index 0 holds the oldest sample, which meets tap 0.
	logic signed [SAMPLE_W-1:0] i_window [TAP_COUNT];
	logic signed [SAMPLE_W-1:0] q_window [TAP_COUNT];
	shaped_sample_t             shaped_queue [$];
	shaped_sample_t             predicted;
	longint                     i_sum;
	longint                     q_sum;
	int                         mismatch_total = 0;
	int                         shaped_waiting = 0;

	assign error_count     = mismatch_total;
	assign results_pending = shaped_waiting;

	task automatic report(input string msg);
		$display("%0t: ERROR %s", $time, msg);
		mismatch_total++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] round_saturate(input longint sum,
			inout logic clip);
		longint scaled;
		// Adding half an LSB before the arithmetic shift sends ties toward plus infinity.
		scaled = (sum + ROUND_HALF) >>> FRAC_W;
		if (scaled > SAT_MAX) begin
			clip = 1'b1;
			return SAMPLE_W'(SAT_MAX);
		end
		if (scaled < SAT_MIN) begin
			clip = 1'b1;
			return SAMPLE_W'(SAT_MIN);
		end
		return scaled[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_COUNT; k++) begin
				tap_weight[k] = '0;
				i_window[k]   = '0;
				q_window[k]   = '0;
			end
			shaped_queue.delete();
			shaped_waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (shaped_queue.size() == 0) begin
					report($sformatf("result with nothing expected: i %0d q %0d clipped %0b",
						i_result, q_result, clipped));
				end else begin
					predicted = shaped_queue.pop_front();
					if (i_result !== predicted.i_val)
						report($sformatf("i_result expected %0d, got %0d",
							predicted.i_val, i_result));
					if (q_result !== predicted.q_val)
						report($sformatf("q_result expected %0d, got %0d",
							predicted.q_val, q_result));
					if (clipped !== predicted.clip)
						report($sformatf("clipped expected %0b, got %0b",
							predicted.clip, clipped));
				end
			end
			if (in_valid && !in_stall) begin
				if (op == OP_LOAD) begin
					if (coeff_index < TAP_COUNT)
						tap_weight[coeff_index] = coeff_value;
				end else begin
					for (int k = 0; k < TAP_COUNT - 1; k++) begin
						i_window[k] = i_window[k + 1];
						q_window[k] = q_window[k + 1];
					end
					i_window[TAP_COUNT - 1] = i_sample;
					q_window[TAP_COUNT - 1] = q_sample;
					i_sum = 0;
					q_sum = 0;
					for (int k = 0; k < TAP_COUNT; k++) begin
						i_sum += longint'(i_window[k]) * longint'(tap_weight[k]);
						q_sum += longint'(q_window[k]) * longint'(tap_weight[k]);
					end
					predicted.clip  = 1'b0;
					predicted.i_val = round_saturate(i_sum, predicted.clip);
					predicted.q_val = round_saturate(q_sum, predicted.clip);
					shaped_queue.push_back(predicted);
				end
			end
			shaped_waiting = shaped_queue.size();
		end
	end

endmodule

### tb/complex_fir_pulse_shaper_tb.sv
// Top of the pulse shaper testbench: clock, reset, request stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module complex_fir_pulse_shaper_tb;
	import cfps_pkg::*;

	localparam int TAP_COUNT       = 33;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic                       op          = OP_LOAD;
	logic [INDEX_W-1:0]         coeff_index = '0;
	logic signed [SAMPLE_W-1:0] coeff_value = '0;
	logic signed [SAMPLE_W-1:0] i_sample    = '0;
	logic signed [SAMPLE_W-1:0] q_sample    = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [SAMPLE_W-1:0] i_result;
	logic signed [SAMPLE_W-1:0] q_result;
	logic                       clipped;
	int                         error_count;
	int                         results_pending;

	int   sender_idle_pct = 0;
	int   stall_pct       = 0;
	logic hold_off        = 1'b0;
	logic pressure_go     = 1'b0;

	complex_fir_pulse_shaper #(
		.TAP_COUNT(TAP_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.i_sample(i_sample),
		.q_sample(q_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.i_result(i_result),
		.q_result(q_result),
		.clipped(clipped)
	);

	complex_fir_pulse_shaper_checker #(
		.TAP_COUNT(TAP_COUNT)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.i_sample(i_sample),
		.q_sample(q_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.i_result(i_result),
		.q_result(q_result),
		.clipped(clipped),
		.error_count(error_count),
		.results_pending(results_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// Long receiver hold-off so that a finished result and a pending pass back up the input.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return SAMPLE_W'(int'($urandom_range(4095)) - 2048);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// in_valid stays high from one request to the next unless a gap is drawn.
	task automatic send_request(input logic req_op, input logic [INDEX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] cval, input logic signed [SAMPLE_W-1:0] isamp,
			input logic signed [SAMPLE_W-1:0] qsamp);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= req_op;
		coeff_index <= idx;
		coeff_value <= cval;
		i_sample    <= isamp;
		q_sample    <= qsamp;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic run_random(input int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 20)
				send_request(OP_LOAD,
					(roll < 3) ? INDEX_W'($urandom_range(63, TAP_COUNT))
						: INDEX_W'($urandom_range(TAP_COUNT - 1)),
					pick_value(), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			else
				send_request(OP_SAMPLE, INDEX_W'($urandom), SAMPLE_W'($urandom),
					pick_value(), pick_value());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With an empty tap table every output is zero, whatever the samples.
		send_request(OP_SAMPLE, 6'd0, 16'sd0, S_MAX, S_MIN);
		send_request(OP_SAMPLE, 6'd63, S_MIN, S_MIN, S_MAX);
		// Loads beyond the last tap must leave the table alone.
		send_request(OP_LOAD, 6'd63, S_MAX, S_MAX, S_MAX);
		send_request(OP_LOAD, 6'd33, S_MIN, S_MIN, S_MIN);
		// Half-LSB sums on both signs check the rounding of ties.
		send_request(OP_LOAD, 6'd32, 16'sd16384, 16'sd0, 16'sd0);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, 16'sd1, -16'sd1);
		send_request(OP_LOAD, 6'd32, S_MAX, 16'sd0, 16'sd0);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, S_MIN, S_MAX);
		// Two full-scale taps push the sums past both rails.
		send_request(OP_LOAD, 6'd31, S_MIN, 16'sd0, 16'sd0);
		send_request(OP_LOAD, 6'd32, S_MIN, 16'sd0, 16'sd0);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, S_MIN, S_MIN);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, S_MAX, 16'sd0);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, S_MAX, 16'sd0);
		send_request(OP_LOAD, 6'd0, S_MAX, 16'sd0, 16'sd0);
		send_request(OP_LOAD, 6'd16, -16'sd1, 16'sd0, 16'sd0);
		send_request(OP_SAMPLE, 6'd0, 16'sd0, 16'sd0, 16'sd0);

		run_random(300);
		sender_idle_pct = 67;
		run_random(300);
		sender_idle_pct = 0;
		stall_pct <= 67;
		run_random(300);
		sender_idle_pct = 38;
		stall_pct <= 38;
		run_random(300);

		sender_idle_pct = 0;
		stall_pct <= 0;
		pressure_go <= 1'b1;
		for (int n = 0; n < 12; n++)
			send_request(OP_SAMPLE, INDEX_W'($urandom), SAMPLE_W'($urandom),
				pick_value(), pick_value());

		in_valid <= 1'b0;
		@(posedge clk);
		wait (results_pending == 0);
		repeat (TAP_COUNT + 10) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
rtl/cfps_pkg.sv
rtl/cfps_tap_cell.sv
rtl/cfps_round_sat.sv
rtl/complex_fir_pulse_shaper.sv
tb/complex_fir_pulse_shaper_checker.sv
tb/complex_fir_pulse_shaper_tb.sv
